FILE: sv/int128_alu_defines.svh
// assertion macros for the int128 alu
`ifndef INT128_ALU_DEFINES_SVH
`define INT128_ALU_DEFINES_SVH
`ifndef SYNTHESIS
`define ALU_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("alu check failed");
`define ALU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("alu check failed");
`else
`define ALU_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define ALU_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: sv/i128a_pkg.sv
// shared types and codes for the int128 alu
package i128a_pkg;
    typedef enum logic [3:0] {
        OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
        OP_AND = 4'd4, OP_OR = 4'd5, OP_XOR = 4'd6, OP_NOT = 4'd7,
        OP_SHL = 4'd8, OP_SHR = 4'd9, OP_ROL = 4'd10, OP_ROR = 4'd11,
        OP_CMP = 4'd12
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE, ST_RUN, ST_FIX, ST_DONE
    } state_t;

    localparam int HALF_BITS = 64;
    localparam int FULL_BITS = 128;
    localparam int SHAMT_BITS = 7;
endpackage

FILE: sv/int128_alu.sv
// Sequential 128-bit signed integer ALU, every operation processed one bit per cycle.
// All operations go through a bit-serial datapath: from acceptance to result valid each item
// runs WORD_BITS serial steps, then a fix-up state for sign correction and sign extension;
// every operation runs the serial loop for the full WORD_BITS steps; multiply is
// shift-add and divide is restoring, one operand bit per step. One item is in work at a
// time; the result register holds until taken, and the next item is accepted in the
// cycle after it has been taken.
module int128_alu #(
    parameter int WORD_BITS = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_kind,
    input  logic [63:0] s_a_high,
    input  logic [63:0] s_a_low,
    input  logic [63:0] s_b_high,
    input  logic [63:0] s_b_low,
    input  logic [6:0]  s_shift_amount,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_high,
    output logic [63:0] m_result_low,
    output logic        m_is_less,
    output logic        m_is_equal,
    output logic        m_divide_by_zero
);
    import i128a_pkg::*;
`include "int128_alu_defines.svh"

    localparam int W = WORD_BITS;
    localparam int CB = $clog2(W + 1);

    state_t state_reg, state_next;
    logic [CB-1:0] cnt_reg;
    logic [3:0] kind_reg;
    logic [W-1:0] a_reg, b_reg, r_reg, q_reg, rot_reg;
    logic [W-1:0] x_reg;
    logic [6:0] sh_reg;
    logic carry_reg, eq_reg, lt_reg, na_reg, nb_reg, dz_reg;
    logic [63:0] oh_reg, ol_reg;
    logic olt_reg, oeq_reg, odz_reg;
    logic [W-1:0] a_in, b_in;
    logic [W:0] rem_sh;
    logic [W:0] rem_sub;
    logic [W-1:0] res;
    logic [FULL_BITS-1:0] res_ext;
    logic [6:0] sh_mod;
    logic shift_kind;

    // shift count modulo the word width by compare and subtract
    function automatic logic [6:0] shamt_mod(input logic [6:0] x);
        logic [10:0] t;
        t = {4'b0, x};
        for (int k = 3; k >= 0; k--) begin
            if (t >= 11'(W << k)) t = t - 11'(W << k);
        end
        return t[6:0];
    endfunction

    assign a_in = W'({s_a_high, s_a_low});
    assign b_in = W'({s_b_high, s_b_low});
    assign sh_mod = shamt_mod(s_shift_amount);
    assign shift_kind = (s_kind >= OP_SHL) && (s_kind <= OP_ROR);

    // divide: remainder shifts in one dividend bit per step
    assign rem_sh = {r_reg, x_reg[W-1]};
    assign rem_sub = rem_sh - {1'b0, b_reg};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_RUN;
            ST_RUN:  if (cnt_reg == CB'(W - 1)) state_next = ST_FIX;
            ST_FIX:  state_next = ST_DONE;
            ST_DONE: if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = (state_reg == ST_IDLE);
        m_valid = (state_reg == ST_DONE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        res = '0;
        case (op_t'(kind_reg))
            OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR, OP_NOT,
            OP_SHL, OP_SHR: res = r_reg;
            OP_ROL, OP_ROR: res = rot_reg;
            OP_DIV: res = dz_reg ? '0 : ((na_reg ^ nb_reg) ? -q_reg : q_reg);
            default: res = '0;
        endcase
        res_ext = FULL_BITS'($signed(res));
    end

    // serial datapath: one bit position per cycle
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_reg <= s_kind;
                    sh_reg <= sh_mod;
                    cnt_reg <= '0;
                    carry_reg <= (s_kind == OP_SUB);
                    eq_reg <= 1'b1;
                    lt_reg <= 1'b0;
                    na_reg <= a_in[W-1];
                    nb_reg <= b_in[W-1];
                    dz_reg <= (b_in == '0);
                    // shifts and rotates start from the operand itself
                    r_reg <= shift_kind ? a_in : '0;
                    q_reg <= '0;
                    rot_reg <= a_in;
                    // divide works on magnitudes
                    a_reg <= (s_kind == OP_DIV && a_in[W-1]) ? -a_in : a_in;
                    x_reg <= (s_kind == OP_DIV && a_in[W-1]) ? -a_in : a_in;
                    b_reg <= (s_kind == OP_DIV && b_in[W-1]) ? -b_in : b_in;
                end
            end
            ST_RUN: begin
                cnt_reg <= cnt_reg + 1'b1;
                case (op_t'(kind_reg))
                    OP_ADD, OP_SUB: begin
                        logic bb;
                        bb = (kind_reg == OP_SUB) ? ~b_reg[0] : b_reg[0];
                        r_reg <= {a_reg[0] ^ bb ^ carry_reg, r_reg[W-1:1]};
                        carry_reg <= (a_reg[0] & bb) | (carry_reg & (a_reg[0] ^ bb));
                        a_reg <= a_reg >> 1;
                        b_reg <= b_reg >> 1;
                    end
                    OP_MUL: begin
                        if (b_reg[0]) r_reg <= r_reg + a_reg;
                        a_reg <= a_reg << 1;
                        b_reg <= b_reg >> 1;
                    end
                    OP_DIV: begin
                        x_reg <= x_reg << 1;
                        if (!rem_sub[W]) begin
                            r_reg <= rem_sub[W-1:0];
                            q_reg <= {q_reg[W-2:0], 1'b1};
                        end else begin
                            r_reg <= rem_sh[W-1:0];
                            q_reg <= {q_reg[W-2:0], 1'b0};
                        end
                    end
                    OP_AND, OP_OR, OP_XOR, OP_NOT: begin
                        logic rb;
                        case (op_t'(kind_reg))
                            OP_AND: rb = a_reg[0] & b_reg[0];
                            OP_OR:  rb = a_reg[0] | b_reg[0];
                            OP_XOR: rb = a_reg[0] ^ b_reg[0];
                            default: rb = ~a_reg[0];
                        endcase
                        r_reg <= {rb, r_reg[W-1:1]};
                        a_reg <= a_reg >> 1;
                        b_reg <= b_reg >> 1;
                    end
                    OP_SHL, OP_SHR, OP_ROL, OP_ROR: begin
                        // one-position step while the count runs below the amount
                        if (CB'(sh_reg) > cnt_reg) begin
                            if (kind_reg == OP_SHL) r_reg <= r_reg << 1;
                            else r_reg <= r_reg >> 1;
                            if (kind_reg == OP_ROL)
                                rot_reg <= {rot_reg[W-2:0], rot_reg[W-1]};
                            else
                                rot_reg <= {rot_reg[0], rot_reg[W-1:1]};
                        end
                    end
                    OP_CMP: begin
                        // lsb first: a higher differing bit overrides lower ones
                        if (a_reg[0] != b_reg[0]) begin
                            eq_reg <= 1'b0;
                            lt_reg <= (cnt_reg == CB'(W - 1)) ? a_reg[0] : b_reg[0];
                        end
                        a_reg <= a_reg >> 1;
                        b_reg <= b_reg >> 1;
                    end
                    default: ;
                endcase
            end
            ST_FIX: begin
                oh_reg <= res_ext[127:64];
                ol_reg <= res_ext[63:0];
                olt_reg <= (kind_reg == OP_CMP) & lt_reg;
                oeq_reg <= (kind_reg == OP_CMP) & eq_reg;
                odz_reg <= (kind_reg == OP_DIV) & dz_reg;
            end
            default: ;
        endcase
    end

    assign m_result_high = oh_reg;
    assign m_result_low = ol_reg;
    assign m_is_less = olt_reg;
    assign m_is_equal = oeq_reg;
    assign m_divide_by_zero = odz_reg;

    `ALU_ASSERT_IMPL(a_hs_excl, aclk, aresetn, 1'b1, !(s_ready && m_valid))
    `ALU_ASSERT_IMPL(a_flag_excl, aclk, aresetn, m_valid, !(m_is_less && m_is_equal))
    `ALU_ASSERT_NEXT(a_start, aclk, aresetn, s_valid && s_ready, state_reg == ST_RUN)
endmodule
